// ===== design/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache: item structs,
// opcodes, configuration defaults and the controller command bundle.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // capacity register
    localparam int          CFG_W     = 5;
    localparam logic [4:0]  CFG_RESET = 5'd16;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        lookup_key;
        logic signed [31:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic [31:0]        evicted_key;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic match;
        logic decide;
        logic commit;
    } t_ctl_cmd;

endpackage

// ===== design/lkv_ram.sv =====
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lkv_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer for one cache access: capture, key match, slot decision and
// commit, then a one-cycle done strobe.
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output lkv_pkg::t_ctl_cmd o_cmd
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) begin
                n_state = S_MATCH;
            end
            S_MATCH:  n_state = S_DECIDE;
            S_DECIDE: n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_COMMIT);
        end
    end

    // commands
    always_comb begin
        o_cmd.capture = i_start && (r_state == S_IDLE);
        o_cmd.match   = (r_state == S_MATCH);
        o_cmd.decide  = (r_state == S_DECIDE);
        o_cmd.commit  = (r_state == S_COMMIT);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== design/lkv_dpath.sv =====
// ----------------------------------------------------------------------------
// lkv_dpath
// Slot storage and access datapath: parallel key compare, age tracking,
// free and oldest slot search, value and key RAMs and the result register.
// ----------------------------------------------------------------------------
module lkv_dpath #(
    parameter int ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lkv_pkg::t_ctl_cmd   i_cmd,
    input  lkv_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data,
    output lkv_pkg::t_out_item  o_result
);
    import lkv_pkg::*;

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW    = IW;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // slot state
    t_in_item             r_in;
    logic [ENTRIES-1:0]   r_valid;
    logic [31:0]          r_key [ENTRIES];
    logic [AW-1:0]        r_age [ENTRIES];
    logic [CNT_W-1:0]     r_occ;
    logic [CFG_W-1:0]     r_cfg;

    // match stage results
    logic                 r_hit;
    logic [IW-1:0]        r_hit_idx;
    logic [AW-1:0]        r_hit_age;
    logic [IW-1:0]        r_old_idx;
    logic [IW-1:0]        r_free_idx;
    logic                 r_have_free;
    logic                 r_room;

    // decision
    logic [IW-1:0]        r_target;
    logic                 r_ev;
    logic                 r_ins;

    t_out_item            r_result;

    logic [ENTRIES-1:0]   match_vec;
    logic [ENTRIES-1:0]   old_vec;
    logic [IW-1:0]        hit_idx;
    logic [AW-1:0]        hit_age;
    logic [IW-1:0]        old_idx;
    logic [IW-1:0]        free_idx;
    logic [CNT_W-1:0]     eff_cap;
    logic [31:0]          rd_value;
    logic [31:0]          rd_key;
    logic                 value_we;
    logic                 key_we;

    // parallel key compare and oldest slot vector
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = r_valid[i] && (r_key[i] == r_in.lookup_key);
            old_vec[i]   = r_valid[i] && ((CNT_W'(r_age[i]) + CNT_W'(1)) == r_occ);
        end
    end

    // one-hot to index, hit age
    always_comb begin
        hit_idx = '0;
        hit_age = '0;
        old_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i]) begin
                hit_idx = hit_idx | IW'(i);
                hit_age = hit_age | r_age[i];
            end
            if (old_vec[i]) begin
                old_idx = old_idx | IW'(i);
            end
        end
    end

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    // capacity: zero reads as one, saturate at slot count
    always_comb begin
        if (r_cfg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(r_cfg) > ENTRIES) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(r_cfg);
        end
    end

    // input capture and per-stage registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_item;
        end
        if (i_cmd.match) begin
            r_hit       <= |match_vec;
            r_hit_idx   <= hit_idx;
            r_hit_age   <= hit_age;
            r_old_idx   <= old_idx;
            r_free_idx  <= free_idx;
            r_have_free <= ~&r_valid;
            r_room      <= (r_occ < eff_cap);
        end
        if (i_cmd.decide) begin
            r_target <= r_hit_idx;
            r_ev     <= 1'b0;
            r_ins    <= 1'b0;
            if (!r_hit && r_in.opcode == OP_PUT) begin
                r_ins <= 1'b1;
                if (r_room && r_have_free) begin
                    r_target <= r_free_idx;
                end else if (r_occ != '0) begin
                    r_target <= r_old_idx;
                    r_ev     <= 1'b1;
                end else begin
                    r_target <= r_free_idx;
                end
            end
        end
    end

    // slot key registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_ins) begin
            r_key[r_target] <= r_in.lookup_key;
        end
    end

    // valid, age, occupancy and capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cfg   <= CFG_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.commit && (r_hit || r_ins)) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && IW'(i) != r_target
                            && (r_ins || r_age[i] < r_hit_age)) begin
                        r_age[i] <= r_age[i] + AW'(1);
                    end
                end
                r_age[r_target] <= '0;
                if (r_ins) begin
                    r_valid[r_target] <= 1'b1;
                    if (!r_ev) begin
                        r_occ <= r_occ + CNT_W'(1);
                    end
                end
            end
        end
    end

    // value and key RAMs, read ports follow the match stage indexes
    assign value_we = i_cmd.commit && (r_in.opcode == OP_PUT) && (r_hit || r_ins);
    assign key_we   = i_cmd.commit && r_ins;

    lkv_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (value_we),
        .i_waddr (r_target),
        .i_wdata ($unsigned(r_in.write_value)),
        .i_raddr (r_hit_idx),
        .o_rdata (rd_value)
    );

    lkv_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_target),
        .i_wdata (r_in.lookup_key),
        .i_raddr (r_old_idx),
        .o_rdata (rd_key)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result.hit         <= r_hit;
            r_result.read_value  <= (r_hit && r_in.opcode == OP_GET) ? rd_value : '0;
            r_result.evicted     <= r_ev;
            r_result.evicted_key <= r_ev ? rd_key : '0;
        end
    end

    assign o_result = r_result;

`ifndef SYNTH
    // occupancy tracks the valid marks
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy count differs from valid slot count");

    // keys of valid slots are unique
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("more than one slot matches the key");

    // a non-empty store always has exactly one least recent slot
    a_oldest_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != '0) |-> $onehot(old_vec))
        else $error("least recent slot not unique");

    // eviction only replaces an entry, never on a hit
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_ev) |-> (!r_hit && r_ins))
        else $error("eviction outside a put miss");
`endif

endmodule

// ===== design/lru_key_value_cache.sv =====
// Sequence: an accepted start steps through the match, decide and commit states;
// o_done and the result are registered at the end of commit; the receiver cannot stall.
// Only one item is in flight: a new start is taken only while idle, and the match,
// decide and commit steps wrap around the registered value and key RAM reads.
// Reset: synchronous active low; clears all valid marks, ages and occupancy,
// and sets the capacity register to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least recently used replacement
// and a configurable capacity.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  lkv_pkg::t_in_item  i_item,
    output logic               o_done,
    output lkv_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_data
);
    import lkv_pkg::*;

    t_ctl_cmd cmd;
    logic     busy;
    logic     cfg_we;

    // configuration taken only while idle
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && !busy;
    assign o_busy      = busy;

    lkv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    lkv_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

endmodule
